// File: design/impulse_noise_blanker_defines.svh
// Assertion macros used by the checker file of the blanker.
// Each one samples on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef IMPULSE_NOISE_BLANKER_DEFINES_SVH
`define IMPULSE_NOISE_BLANKER_DEFINES_SVH

// Same-cycle implication
`define INB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define INB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/inb_pkg.sv
`default_nettype none

package inb_pkg;

  // Sample format
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAG_W       = SAMPLE_BITS;  // peak magnitude reaches 2^(SAMPLE_BITS-1)

  // Ring and gate sizes
  localparam int unsigned MAG_DEPTH   = 32768;
  localparam int unsigned DELAY_DEPTH = 8192;
  localparam int unsigned GATE_MAX    = 4096;

  localparam int unsigned MAG_AW = $clog2(MAG_DEPTH);
  localparam int unsigned DLY_AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(GATE_MAX + 1);

  // Register widths
  localparam int unsigned GATE_LEN_W  = 13;
  localparam int unsigned DELAY_LEN_W = 12;
  localparam int unsigned MAG_LEN_W   = 15;
  localparam int unsigned RATIO_W     = 23;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned CFG_IDX_W   = 2;

  // Datapath widths
  localparam int unsigned SMP_W  = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W  = MAG_AW + MAG_W;
  localparam int unsigned FRAC_W = 8;                 // ratio is Q15.8
  localparam int unsigned PROD_W = MAG_W + RATIO_W;
  localparam int unsigned CMP_W  = (PROD_W > SUM_W + FRAC_W) ? PROD_W : SUM_W + FRAC_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_LEN  = 2'd0,
    CFG_DELAY_LEN = 2'd1,
    CFG_MAG_LEN   = 2'd2,
    CFG_RATIO     = 2'd3
  } cfg_idx_e;

  // Item leaving the ring update stage toward the gate
  typedef struct packed {
    logic [PROD_W-1:0]      prod;
    logic [SUM_W-1:0]       sum;
    logic [SAMPLE_BITS-1:0] re;
    logic [SAMPLE_BITS-1:0] im;
  } inb_s2_t;

endpackage

`default_nettype wire

// File: design/impulse_noise_blanker.sv
// Impulse noise blanker for complex baseband samples.
// Input channel: in_valid_i / in_stall_o with sample_re_i, sample_im_i.
// Output channel: out_valid_o / out_stall_i with out_re_o, out_im_o and
// blanked_o. An item moves when valid is high and stall is low.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 gate_len, 1 delay_len, 2 mag_len, 3 ratio. Write only while idle.
// Each item yields exactly one result, which passes through stage 1, stage 2
// and the output register. One item is taken every cycle unless a stalled
// result holds the pipeline: each ring memory has one read and one write
// port, and the read of an item overlaps the write-back of the item before
// it, with forwarding when both hit one entry.
// Reset clears control state and loads the register defaults; both rings
// read as zero until written, tracked by fill marks, so there is no clearing
// pass and items are taken from the first cycle after reset.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall_o is raised in the same cycle.
`default_nettype none

module impulse_noise_blanker import inb_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      out_re_o,
  output logic signed [SAMPLE_BITS-1:0]      out_im_o,
  output logic                               blanked_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  logic [GATE_LEN_W-1:0]  gate_len_q;
  logic [DELAY_LEN_W-1:0] delay_len_q;
  logic [MAG_LEN_W-1:0]   mag_len_q;
  logic [RATIO_W-1:0]     ratio_q;

  logic             adv, acc;
  logic [MAG_W-1:0] abs_re, abs_im, mag;
  logic             s2_vld;
  inb_s2_t          s2;

  // Pipeline moves unless a held result is stalled
  assign adv        = !out_valid_o || !out_stall_i;
  assign acc        = in_valid_i && adv;
  assign in_stall_o = !adv;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_len_q  <= GATE_LEN_W'(3);
      delay_len_q <= DELAY_LEN_W'(1);
      mag_len_q   <= MAG_LEN_W'(1);
      ratio_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GATE_LEN:  gate_len_q  <= cfg_data_i[GATE_LEN_W-1:0];
        CFG_DELAY_LEN: delay_len_q <= cfg_data_i[DELAY_LEN_W-1:0];
        CFG_MAG_LEN:   mag_len_q   <= cfg_data_i[MAG_LEN_W-1:0];
        CFG_RATIO:     ratio_q     <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Peak magnitude max(|re|, |im|); the most negative input maps to 2^(N-1)
  assign abs_re = sample_re_i[SAMPLE_BITS-1] ? MAG_W'(-sample_re_i) : MAG_W'(sample_re_i);
  assign abs_im = sample_im_i[SAMPLE_BITS-1] ? MAG_W'(-sample_im_i) : MAG_W'(sample_im_i);
  assign mag    = (abs_re > abs_im) ? abs_re : abs_im;

  inb_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .acc_i       (acc),
    .re_i        (sample_re_i),
    .im_i        (sample_im_i),
    .mag_i       (mag),
    .mag_len_i   (mag_len_q),
    .delay_len_i (delay_len_q),
    .ratio_i     (ratio_q),
    .s2_vld_o    (s2_vld),
    .s2_o        (s2)
  );

  inb_gate u_gate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s2_vld_i   (s2_vld),
    .s2_i       (s2),
    .gate_len_i (gate_len_q),
    .out_vld_o  (out_valid_o),
    .out_re_o   (out_re_o),
    .out_im_o   (out_im_o),
    .blanked_o  (blanked_o)
  );

endmodule

`default_nettype wire

// File: design/inb_ram.sv
`default_nettype none

module inb_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; a read of the entry being
  // written returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/inb_update.sv
`default_nettype none

module inb_update import inb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire logic                   acc_i,
  input  wire logic [SAMPLE_BITS-1:0] re_i,
  input  wire logic [SAMPLE_BITS-1:0] im_i,
  input  wire logic [MAG_W-1:0]       mag_i,
  input  wire logic [MAG_LEN_W-1:0]   mag_len_i,
  input  wire logic [DELAY_LEN_W-1:0] delay_len_i,
  input  wire logic [RATIO_W-1:0]     ratio_i,
  output logic                        s2_vld_o,
  output inb_s2_t                     s2_o
);

  localparam logic [MAG_AW-1:0] MAG_LAST = MAG_AW'(MAG_DEPTH - 1);
  localparam logic [DLY_AW-1:0] DLY_LAST = DLY_AW'(DELAY_DEPTH - 1);

  // Ring positions and fill marks
  logic [MAG_AW-1:0] mlen, midx_q, midx_d;
  logic [DLY_AW-1:0] dlen, didx_q, didx_d;
  logic [MAG_AW:0]   minc, mwinc, mfill_q;
  logic [DLY_AW:0]   dinc, dwinc, dfill_q;

  // Stage 1: item whose ring reads are in flight
  logic                   s1_vld_q;
  logic [SAMPLE_BITS-1:0] s1_re_q, s1_im_q;
  logic [MAG_W-1:0]       s1_mag_q;
  logic [MAG_AW-1:0]      s1_maddr_q;
  logic [DLY_AW-1:0]      s1_daddr_q;
  logic                   s1_mhit_q, s1_dhit_q;
  logic [MAG_W-1:0]       s1_mfwd_q;
  logic [SMP_W-1:0]       s1_dfwd_q;

  logic              wr;
  logic [MAG_W-1:0]  mrd, old_mag;
  logic [SMP_W-1:0]  drd, old_smp;
  logic              mvalid, dvalid;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PROD_W-1:0] prod;

  logic    s2_vld_q;
  inb_s2_t s2_q;

  // Next write positions, wrapping once past the current length
  assign mlen   = (mag_len_i > MAG_LAST) ? MAG_LAST : mag_len_i;
  assign dlen   = (DLY_AW'(delay_len_i) > DLY_LAST) ? DLY_LAST : DLY_AW'(delay_len_i);
  assign minc   = (MAG_AW + 1)'(midx_q) + 1'b1;
  assign dinc   = (DLY_AW + 1)'(didx_q) + 1'b1;
  assign midx_d = (minc > (MAG_AW + 1)'(mlen)) ? '0 : minc[MAG_AW-1:0];
  assign didx_d = (dinc > (DLY_AW + 1)'(dlen)) ? '0 : dinc[DLY_AW-1:0];

  // Stage 1 writes back when it moves on
  assign wr    = adv_i & s1_vld_q;
  assign mwinc = (MAG_AW + 1)'(s1_maddr_q) + 1'b1;
  assign dwinc = (DLY_AW + 1)'(s1_daddr_q) + 1'b1;

  inb_ram #(
    .Depth (MAG_DEPTH),
    .Width (MAG_W)
  ) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (s1_maddr_q),
    .wdata_i (s1_mag_q),
    .re_i    (acc_i),
    .raddr_i (midx_q),
    .rdata_o (mrd)
  );

  inb_ram #(
    .Depth (DELAY_DEPTH),
    .Width (SMP_W)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (s1_daddr_q),
    .wdata_i ({s1_re_q, s1_im_q}),
    .re_i    (acc_i),
    .raddr_i (didx_q),
    .rdata_o (drd)
  );

  // Entries at or above the fill mark were never written and read as zero;
  // a write landing on the same edge as the read is forwarded
  assign mvalid  = (MAG_AW + 1)'(s1_maddr_q) < mfill_q;
  assign dvalid  = (DLY_AW + 1)'(s1_daddr_q) < dfill_q;
  assign old_mag = s1_mhit_q ? s1_mfwd_q : (mvalid ? mrd : '0);
  assign old_smp = s1_dhit_q ? s1_dfwd_q : (dvalid ? drd : '0);

  // Moving sum and detection product
  assign sum_d = sum_q - SUM_W'(old_mag) + SUM_W'(s1_mag_q);
  assign prod  = PROD_W'(s1_mag_q) * PROD_W'(ratio_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midx_q   <= '0;
      didx_q   <= '0;
      mfill_q  <= '0;
      dfill_q  <= '0;
      sum_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (adv_i) begin
        s1_vld_q <= acc_i;
        s2_vld_q <= s1_vld_q;
      end
      if (acc_i) begin
        midx_q <= midx_d;
        didx_q <= didx_d;
      end
      if (wr) begin
        sum_q <= sum_d;
        if (mwinc > mfill_q) begin
          mfill_q <= mwinc;
        end
        if (dwinc > dfill_q) begin
          dfill_q <= dwinc;
        end
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_re_q    <= re_i;
      s1_im_q    <= im_i;
      s1_mag_q   <= mag_i;
      s1_maddr_q <= midx_q;
      s1_daddr_q <= didx_q;
      s1_mhit_q  <= wr & (s1_maddr_q == midx_q);
      s1_dhit_q  <= wr & (s1_daddr_q == didx_q);
      s1_mfwd_q  <= s1_mag_q;
      s1_dfwd_q  <= {s1_re_q, s1_im_q};
    end
    if (adv_i) begin
      s2_q.prod <= prod;
      s2_q.sum  <= sum_d;
      s2_q.re   <= old_smp[SMP_W-1:SAMPLE_BITS];
      s2_q.im   <= old_smp[SAMPLE_BITS-1:0];
    end
  end

  assign s2_vld_o = s2_vld_q;
  assign s2_o     = s2_q;

endmodule

`default_nettype wire

// File: design/inb_gate.sv
`default_nettype none

module inb_gate import inb_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic                    s2_vld_i,
  input  wire inb_s2_t                 s2_i,
  input  wire logic [GATE_LEN_W-1:0]   gate_len_i,
  output logic                         out_vld_o,
  output logic signed [SAMPLE_BITS-1:0] out_re_o,
  output logic signed [SAMPLE_BITS-1:0] out_im_o,
  output logic                         blanked_o
);

  logic [CNT_W-1:0] glen, cnt_q, cnt_cur, cnt_d;
  logic             hit, blank;
  logic             out_vld_q, blanked_q;
  logic [SAMPLE_BITS-1:0] out_re_q, out_im_q;

  // Threshold: mag * ratio > sum * 256, exact
  assign glen    = (gate_len_i > GATE_LEN_W'(GATE_MAX)) ? CNT_W'(GATE_MAX)
                                                         : CNT_W'(gate_len_i);
  assign hit     = CMP_W'(s2_i.prod) > CMP_W'({s2_i.sum, FRAC_W'(0)});
  assign cnt_cur = hit ? glen : cnt_q;
  assign blank   = cnt_cur != '0;
  assign cnt_d   = blank ? cnt_cur - 1'b1 : cnt_cur;

  // Blank counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= s2_vld_i;
      if (s2_vld_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv_i && s2_vld_i) begin
      out_re_q  <= blank ? '0 : s2_i.re;
      out_im_q  <= blank ? '0 : s2_i.im;
      blanked_q <= blank;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_re_o  = out_re_q;
  assign out_im_o  = out_im_q;
  assign blanked_o = blanked_q;

endmodule

`default_nettype wire

// File: design/inb_checker.sv
`default_nettype none
`include "impulse_noise_blanker_defines.svh"

module inb_checker import inb_pkg::*; (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [SAMPLE_BITS-1:0] out_re_o,
  input wire logic signed [SAMPLE_BITS-1:0] out_im_o,
  input wire logic                          blanked_o
);

  // A stalled result stays offered
  `INB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // A stalled result keeps its payload
  `INB_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i,
                  $stable(out_re_o) && $stable(out_im_o) && $stable(blanked_o),
                  "result changed under stall")

  // A blanked result carries a zero sample
  `INB_ASSERT_IMP(a_blank_zero, out_valid_o && blanked_o,
                  out_re_o == '0 && out_im_o == '0, "blanked result not zero")

  // With the output register empty the input is never held off
  `INB_ASSERT_IMP(a_no_false_stall, !out_valid_o, !in_stall_o, "input stalled with empty output")

endmodule

bind impulse_noise_blanker inb_checker u_inb_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import inb_pkg::*;

  localparam int unsigned RATIO_MAX  = (1 << RATIO_W) - 1;
  localparam int unsigned GATE_ALL   = (1 << GATE_LEN_W) - 1;
  localparam int unsigned DELAY_MAX  = (1 << DELAY_LEN_W) - 1;
  localparam int unsigned MAG_MAX    = (1 << MAG_LEN_W) - 1;
  localparam int unsigned RAND_ITEMS = 1950;
  localparam int unsigned SETTLE     = 8;        // output latency plus margin
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned DIR_STEPS  = 31;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          blk;
  } blank_out_t;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e                    kind;
    cfg_idx_e                      idx;
    logic [CFG_DATA_W-1:0]         data;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          typed;
    blank_out_t                    want;
  } dir_step_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  localparam blank_out_t NO_OUT = '0;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_re_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_im_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_re_o;
  logic signed [SAMPLE_BITS-1:0] out_im_o;
  logic                          blanked_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i  = '0;

  impulse_noise_blanker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .blanked_o   (blanked_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Blanker state as the testbench sees it
  logic [GATE_LEN_W-1:0]  gate_len_q  = GATE_LEN_W'(3);
  logic [DELAY_LEN_W-1:0] delay_len_q = DELAY_LEN_W'(1);
  logic [MAG_LEN_W-1:0]   mag_len_q   = MAG_LEN_W'(1);
  logic [RATIO_W-1:0]     ratio_q     = '0;
  bit [MAG_W-1:0]         mag_hist [MAG_DEPTH];
  bit [SMP_W-1:0]         smp_hist [DELAY_DEPTH];
  longint unsigned        mag_total = 0;
  int unsigned            mag_pos   = 0;
  int unsigned            dly_pos   = 0;
  int unsigned            gate_left = 0;

  blank_out_t  expected_out [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 0;

  // Directed items: reset contents, extremes, exact threshold, gate of zero,
  // one-entry rings and rings shrunk past their write position
  dir_step_t dir_steps [DIR_STEPS] = '{
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sh7FFF, 16'sh8000, 1'b1, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sh8000, 16'sh7FFF, 1'b1, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd0,    1'b1,
      '{16'sh7FFF, 16'sh8000, 1'b0}},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   -16'sd1,   16'sd1,    1'b1,
      '{16'sh8000, 16'sh7FFF, 1'b0}},
    '{STEP_WRITE,  CFG_RATIO,     23'd512, 16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd100,  16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    -16'sd100, 1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd101,  16'sd7,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd8000, 16'sh8000, 1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd5,    16'sd5,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_MAG_LEN,   23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_DELAY_LEN, 23'd0,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_RATIO,     23'd256, 16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd7,    -16'sd9,   1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd3,    16'sd3,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_MAG_LEN,   23'd5,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_DELAY_LEN, 23'd5,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd11,   -16'sd11,  1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd12,   -16'sd12,  1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd13,   16'sd13,   1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   -16'sd14,  16'sd14,   1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd15,   16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_MAG_LEN,   23'd1,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_WRITE,  CFG_DELAY_LEN, 23'd1,   16'sd0,    16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd21,   16'sd0,    1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   16'sd0,    16'sd22,   1'b0, NO_OUT},
    '{STEP_SAMPLE, CFG_GATE_LEN,  23'd0,   -16'sd23,  -16'sd23,  1'b0, NO_OUT}
  };

  // One sample through the blanker: moving sum, delay ring and gate
  function automatic blank_out_t blank_predict(logic signed [SAMPLE_BITS-1:0] re,
                                               logic signed [SAMPLE_BITS-1:0] im);
    longint          sre;
    longint          sim;
    longint unsigned mre;
    longint unsigned mim;
    longint unsigned mag;
    int unsigned     mlen;
    int unsigned     dlen;
    int unsigned     glen;
    logic [SMP_W-1:0] oldest;
    blank_out_t      res;
    sre  = re;
    sim  = im;
    mre  = (sre < 0) ? -sre : sre;
    mim  = (sim < 0) ? -sim : sim;
    mag  = (mre > mim) ? mre : mim;
    mlen = (mag_len_q > MAG_DEPTH - 1) ? MAG_DEPTH - 1 : mag_len_q;
    dlen = (delay_len_q > DELAY_DEPTH - 1) ? DELAY_DEPTH - 1 : delay_len_q;
    glen = (gate_len_q > GATE_MAX) ? GATE_MAX : gate_len_q;

    mag_total         = mag_total - mag_hist[mag_pos] + mag;
    mag_hist[mag_pos] = MAG_W'(mag);
    mag_pos           = (mag_pos + 1 > mlen) ? 0 : mag_pos + 1;

    oldest            = smp_hist[dly_pos];
    smp_hist[dly_pos] = {re, im};
    dly_pos           = (dly_pos + 1 > dlen) ? 0 : dly_pos + 1;

    // exact compare, no rounding
    if (mag * ratio_q > (mag_total << FRAC_W)) gate_left = glen;

    if (gate_left != 0) begin
      gate_left--;
      res = '{'0, '0, 1'b1};
    end else begin
      res = '{oldest[SMP_W-1:SAMPLE_BITS], oldest[SAMPLE_BITS-1:0], 1'b0};
    end
    return res;
  endfunction

  // Wait for every result, then let the pipeline settle
  task automatic wait_drain();
    while (expected_out.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GATE_LEN:  gate_len_q  = val[GATE_LEN_W-1:0];
      CFG_DELAY_LEN: delay_len_q = val[DELAY_LEN_W-1:0];
      CFG_MAG_LEN:   mag_len_q   = val[MAG_LEN_W-1:0];
      default:       ratio_q     = val[RATIO_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sender works in bursts; valid stays high across items inside a burst
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] re,
                             logic signed [SAMPLE_BITS-1:0] im,
                             logic typed, blank_out_t want);
    int unsigned gap;
    blank_out_t  model;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i  <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    model = blank_predict(re, im);
    expected_out.push_back(typed ? want : model);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Receiver stall pattern, changing mode every segment
  always @(negedge clk_i) begin : stall_gen
    stall_mode_e mode;
    int unsigned seg_left;
    if (seg_left == 0) begin
      mode     = stall_mode_e'($urandom_range(0, 3));
      seg_left = $urandom_range(16, 160);
    end
    seg_left--;
    case (mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
      default:     out_stall_i <= ((seg_left % 5) < 2);
    endcase
  end

  // Output checker
  always @(posedge clk_i) begin : out_check
    blank_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected output item: re=%0d im=%0d blanked=%0b",
                   out_re_o, out_im_o, blanked_o);
      end else begin
        want = expected_out.pop_front();
        if (out_re_o !== want.re || out_im_o !== want.im || blanked_o !== want.blk) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp re=%0d im=%0d blk=%0b, got re=%0d im=%0d blk=%0b",
                     want.re, want.im, want.blk, out_re_o, out_im_o, blanked_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                   g;
    int unsigned                   d;
    int unsigned                   m;
    int unsigned                   r;
    int unsigned                   amp;
    int unsigned                   n;
    int unsigned                   style;
    int unsigned                   phase;
    int unsigned                   rand_count;
    bit                            long_gate_done;
    logic signed [SAMPLE_BITS-1:0] sre;
    logic signed [SAMPLE_BITS-1:0] sim;
    phase          = 0;
    rand_count     = 0;
    long_gate_done = 1'b0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_STEPS; k++) begin
      if (dir_steps[k].kind == STEP_WRITE)
        write_reg(dir_steps[k].idx, dir_steps[k].data);
      else
        send_sample(dir_steps[k].re, dir_steps[k].im, dir_steps[k].typed, dir_steps[k].want);
    end

    // Random phases, each with its own register setting
    while (rand_count < RAND_ITEMS) begin
      if (!long_gate_done && rand_count > RAND_ITEMS / 2) begin
        // one impulse under the largest gate setting, then quiet samples
        write_reg(CFG_GATE_LEN, CFG_DATA_W'(GATE_ALL));
        write_reg(CFG_RATIO, CFG_DATA_W'(RATIO_MAX));
        write_reg(CFG_MAG_LEN, CFG_DATA_W'(3));
        write_reg(CFG_DELAY_LEN, CFG_DATA_W'(2047));
        send_sample(16'sh7FFF, 16'sh8000, 1'b0, NO_OUT);
        repeat (60) send_sample('0, '0, 1'b0, NO_OUT);
        long_gate_done = 1'b1;
      end

      g = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0:       d = 0;
        1:       d = DELAY_MAX;
        default: d = $urandom_range(1, 48);
      endcase
      case ($urandom_range(0, 9))
        0:       m = 0;
        1:       m = MAG_MAX;
        default: m = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 9))
        0:       r = 0;
        1:       r = RATIO_MAX;
        default: r = (m + 1) * $urandom_range(160, 700);
      endcase
      if (phase == 1) begin
        d = DELAY_MAX;
        m = MAG_MAX;
        r = RATIO_MAX;
      end else if (phase == 2) begin
        r = 0;
      end
      if (r > RATIO_MAX) r = RATIO_MAX;

      write_reg(CFG_GATE_LEN, CFG_DATA_W'(g));
      write_reg(CFG_DELAY_LEN, CFG_DATA_W'(d));
      write_reg(CFG_MAG_LEN, CFG_DATA_W'(m));
      write_reg(CFG_RATIO, CFG_DATA_W'(r));

      // mostly a noise floor with sparse impulses, sometimes full-range noise
      style = $urandom_range(0, 3);
      amp   = $urandom_range(1, 400);
      n     = $urandom_range(30, 220);
      repeat (n) begin
        if (style == 0 || $urandom_range(0, 24) == 0) begin
          sre = SAMPLE_BITS'($urandom);
          sim = SAMPLE_BITS'($urandom);
        end else begin
          sre = SAMPLE_BITS'($urandom_range(0, 2 * amp)) - SAMPLE_BITS'(amp);
          sim = SAMPLE_BITS'($urandom_range(0, 2 * amp)) - SAMPLE_BITS'(amp);
        end
        send_sample(sre, sim, 1'b0, NO_OUT);
      end
      rand_count += n;
      phase++;
    end

    in_valid_i <= 1'b0;
    wait_drain();
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/inb_pkg.sv
design/inb_ram.sv
design/inb_update.sv
design/inb_gate.sv
design/impulse_noise_blanker.sv
design/inb_checker.sv
tb/tb_top.sv
